>>> hdl/tqpp_pkg.sv
`timescale 1ns / 1ps

package tqpp_pkg;

   // field and register widths
   localparam int VAL_W      = 13;
   localparam int BYTES_W    = 10;
   localparam int DATA_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int TAIL_W     = 12;

   // opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_F1          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_F2          = 2'd2;

   // register reset values
   localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = 10'd5;
   localparam logic [VAL_W-1:0]   RST_F1          = 13'd3;
   localparam logic [VAL_W-1:0]   RST_F2          = 13'd10;

   typedef struct packed {
      logic red_load;
      logic red_step;
      logic red_fix;
      logic item_take;
   } tqpp_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic cfg_write;
   } tqpp_status_type;

   // one data step: returns {parity, next state}; bit0 = newest register
   function automatic logic [3:0] rsc_step(input logic [2:0] s, input logic u);
      logic fb;
      logic nb;
      logic par;
      fb  = s[1] ^ s[2];
      nb  = u ^ fb;
      par = nb ^ s[0] ^ s[2];
      return {par, s[1:0], nb};
   endfunction

   // three termination steps: x,z,x,z,x,z in bits 0..5
   function automatic logic [5:0] rsc_tail(input logic [2:0] s);
      logic [2:0] st;
      logic [5:0] o;
      st = s;
      o  = '0;
      for (int k = 0; k < 3; k++) begin
         o[2*k]   = st[1] ^ st[2];
         o[2*k+1] = st[0] ^ st[2];
         st       = {st[1:0], 1'b0};
      end
      return o;
   endfunction

endpackage

>>> hdl/tqpp_ifs.sv
`timescale 1ns / 1ps

interface tqpp_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [tqpp_pkg::DATA_W-1:0]   data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface tqpp_rsp_if;
   logic valid;
   logic ready;
   logic first_bit;
   logic second_bit;
   logic third_bit;
   logic block_end;

   modport source (output valid, output first_bit, output second_bit,
                   output third_bit, output block_end, input ready);
   modport sink   (input valid, input first_bit, input second_bit,
                   input third_bit, input block_end, output ready);
endinterface

interface tqpp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tqpp_pkg::CSR_IDX_W-1:0]    index;
   logic [tqpp_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/turbo_encoder_qpp_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields                                        Word moves when
// req_bus   in   opcode, data_byte                             valid && ready
// rsp_bus   out  first_bit, second_bit, third_bit, block_end   valid && ready
// csr_bus   in   index, data                                   valid (ready tied high)
//
// Every word on req_bus is followed by a settle state in which the registered reads of
// the bit store refetch at the updated bit and interleaver addresses.
// A configuration write, and reset, start a reduction of f1, f2 and the interleaver
// state modulo K in four restoring lanes; req_bus.ready stays low through the load,
// reduce, fix and settle states, so the next word is taken only from the idle state.
// The bit store needs no clearing pass after reset.
// A result waits in the output register; a new word is taken once that slot drains.
module turbo_encoder_qpp_unit #(
   parameter int MAX_BLOCK_BYTES = 768
) (
   input logic        clock,
   input logic        reset,
   tqpp_req_if.sink   req_bus,
   tqpp_rsp_if.source rsp_bus,
   tqpp_csr_if.sink   csr_bus
);

   tqpp_pkg::tqpp_cmd_type    cmd;
   tqpp_pkg::tqpp_status_type status;

   // configuration writes are always taken; the controller restarts the reduction
   assign csr_bus.ready = 1'b1;

   // sequence: reduction, settle, then each taken word followed by a settle state
   tqpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // bit store, RSC encoders, interleaver recursion and the result slot
   tqpp_datapath #(
      .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_bus.opcode),
      .req_data_byte  (req_bus.data_byte),
      .csr_valid      (csr_bus.valid),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_first_bit  (rsp_bus.first_bit),
      .rsp_second_bit (rsp_bus.second_bit),
      .rsp_third_bit  (rsp_bus.third_bit),
      .rsp_block_end  (rsp_bus.block_end)
   );

endmodule

>>> hdl/tqpp_mod_lane.sv
`timescale 1ns / 1ps

// Restoring remainder: one operand bit per step, VAL_W steps.
module tqpp_mod_lane (
   input  logic                        clock,
   input  logic                        start,
   input  logic                        step,
   input  logic [tqpp_pkg::VAL_W-1:0]  operand,
   input  logic [tqpp_pkg::VAL_W-1:0]  modulus,
   output logic [tqpp_pkg::VAL_W-1:0]  remainder
);

   logic [tqpp_pkg::VAL_W-1:0] rem_ff, rem_in;
   logic [tqpp_pkg::VAL_W-1:0] op_ff, op_in;
   logic [tqpp_pkg::VAL_W:0]   trial;

   always_comb begin
      trial  = {rem_ff, op_ff[tqpp_pkg::VAL_W-1]};
      rem_in = rem_ff;
      op_in  = op_ff;
      if (start) begin
         rem_in = '0;
         op_in  = operand;
      end else if (step) begin
         op_in = {op_ff[tqpp_pkg::VAL_W-2:0], 1'b0};
         if (trial >= {1'b0, modulus}) begin
            rem_in = tqpp_pkg::VAL_W'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[tqpp_pkg::VAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      op_ff  <= op_in;
   end

   assign remainder = rem_ff;

endmodule

>>> hdl/tqpp_ctrl.sv
`timescale 1ns / 1ps

module tqpp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tqpp_pkg::tqpp_status_type status,
   output tqpp_pkg::tqpp_cmd_type    cmd
);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_FIX    = 3'd2;
   localparam logic [2:0] ST_SETTLE = 3'd3;
   localparam logic [2:0] ST_IDLE   = 3'd4;

   localparam int CNT_W = $clog2(tqpp_pkg::VAL_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tqpp_pkg::VAL_W - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             take;

   assign req_ready = (state_ff == ST_IDLE) && status.slot_free;
   assign take      = req_ready && req_valid;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_LOAD: begin
            state_in = ST_REDUCE;
            cnt_in   = '0;
         end
         ST_REDUCE: begin
            cnt_in = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX:    state_in = ST_SETTLE;
         ST_SETTLE: state_in = ST_IDLE;
         ST_IDLE: begin
            if (take) begin
               state_in = ST_SETTLE;
            end
         end
         default:   state_in = ST_LOAD;
      endcase
      // new coefficients or length: redo the reduction
      if (status.cfg_write) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      cmd.red_load  = (state_ff == ST_LOAD);
      cmd.red_step  = (state_ff == ST_REDUCE);
      cmd.red_fix   = (state_ff == ST_FIX);
      cmd.item_take = take;
   end

endmodule

>>> hdl/tqpp_datapath.sv
`timescale 1ns / 1ps

module tqpp_datapath #(
   parameter int MAX_BLOCK_BYTES = 768
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tqpp_pkg::tqpp_cmd_type           cmd,
   output tqpp_pkg::tqpp_status_type        status,
   input  logic                             req_opcode,
   input  logic [tqpp_pkg::DATA_W-1:0]      req_data_byte,
   input  logic                             csr_valid,
   input  logic [tqpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tqpp_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_first_bit,
   output logic                             rsp_second_bit,
   output logic                             rsp_third_bit,
   output logic                             rsp_block_end
);

   localparam int VW = tqpp_pkg::VAL_W;
   localparam int BW = tqpp_pkg::BYTES_W;
   localparam int AW = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
   localparam logic [BW-1:0] MAX_B      = BW'(MAX_BLOCK_BYTES);
   localparam logic [VW:0]   STORE_BITS = (VW+1)'(MAX_BLOCK_BYTES * 8);

   // configuration
   logic [BW-1:0] bytes_ff, bytes_in;
   logic [VW-1:0] f1_ff, f1_in;
   logic [VW-1:0] f2_ff, f2_in;
   logic [BW-1:0] eff_bytes;
   logic [VW-1:0] k_bits;

   // block state; pa/pi hold the raw values, pam/pim their copies reduced mod K
   logic [BW-1:0]               lc_ff, lc_in;
   logic [VW-1:0]               ei_ff, ei_in;
   logic [VW-1:0]               pa_ff, pa_in;
   logic [VW-1:0]               pam_ff, pam_in;
   logic [VW-1:0]               pi_ff, pi_in;
   logic [VW-1:0]               pim_ff, pim_in;
   logic [2:0]                  s1_ff, s1_in;
   logic [2:0]                  s2_ff, s2_in;
   logic [tqpp_pkg::TAIL_W-1:0] tail_ff, tail_in;
   logic                        full_ff, full_in;

   // derived coefficients
   logic [VW-1:0] sumf_ff, sumf_in;
   logic [VW-1:0] dbl_ff, dbl_in;
   logic [VW-1:0] r_f1, r_f2, r_pa, r_pi;
   logic [VW:0]   fix_sum, fix_dbl;

   // bit store
   logic [tqpp_pkg::DATA_W-1:0] store_mem [MAX_BLOCK_BYTES];
   logic [tqpp_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]               raddr_a, raddr_b, waddr;
   logic                        sys_ok, ilv_ok, lc_ok;

   // result slot
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_first_ff, rsp_first_in;
   logic rsp_second_ff, rsp_second_in;
   logic rsp_third_ff, rsp_third_in;
   logic rsp_end_ff, rsp_end_in;

   // emit path
   logic                        do_load, do_emit, in_data;
   logic                        sys_bit, ilv_bit;
   logic [3:0]                  step1, step2;
   logic [VW:0]                 pa_sum, pi_sum;
   logic [VW-1:0]               pa_next, pi_next;
   logic [VW-1:0]               diff;
   logic [1:0]                  tsel;
   logic [tqpp_pkg::TAIL_W-1:0] tail_calc, tail_use;
   logic [2:0]                  trip;
   logic [BW-1:0]               lc_inc;

   // ---------------- configuration registers ----------------
   always_comb begin
      bytes_in = bytes_ff;
      f1_in    = f1_ff;
      f2_in    = f2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tqpp_pkg::CSR_BLOCK_BYTES: bytes_in = csr_data[BW-1:0];
            tqpp_pkg::CSR_F1:          f1_in    = csr_data[VW-1:0];
            tqpp_pkg::CSR_F2:          f2_in    = csr_data[VW-1:0];
            default:                   bytes_in = bytes_ff;
         endcase
      end
   end

   always_comb begin
      if (bytes_ff == '0) begin
         eff_bytes = BW'(1);
      end else if (bytes_ff > MAX_B) begin
         eff_bytes = MAX_B;
      end else begin
         eff_bytes = bytes_ff;
      end
   end

   assign k_bits = {eff_bytes, 3'b000};

   // ---------------- modulo lanes ----------------
   tqpp_mod_lane u_lane_f1 (
      .clock(clock), .start(cmd.red_load), .step(cmd.red_step),
      .operand(f1_ff), .modulus(k_bits), .remainder(r_f1)
   );
   tqpp_mod_lane u_lane_f2 (
      .clock(clock), .start(cmd.red_load), .step(cmd.red_step),
      .operand(f2_ff), .modulus(k_bits), .remainder(r_f2)
   );
   tqpp_mod_lane u_lane_pa (
      .clock(clock), .start(cmd.red_load), .step(cmd.red_step),
      .operand(pa_ff), .modulus(k_bits), .remainder(r_pa)
   );
   tqpp_mod_lane u_lane_pi (
      .clock(clock), .start(cmd.red_load), .step(cmd.red_step),
      .operand(pi_ff), .modulus(k_bits), .remainder(r_pi)
   );

   assign fix_sum = {1'b0, r_f1} + {1'b0, r_f2};
   assign fix_dbl = {r_f2, 1'b0};

   always_comb begin
      sumf_in = sumf_ff;
      dbl_in  = dbl_ff;
      if (cmd.red_fix) begin
         sumf_in = (fix_sum >= {1'b0, k_bits}) ? VW'(fix_sum - {1'b0, k_bits})
                                                : fix_sum[VW-1:0];
         dbl_in  = (fix_dbl >= {1'b0, k_bits}) ? VW'(fix_dbl - {1'b0, k_bits})
                                                : fix_dbl[VW-1:0];
      end
   end

   // ---------------- bit store ----------------
   assign sys_ok  = {1'b0, ei_ff} < STORE_BITS;
   assign ilv_ok  = {1'b0, pa_ff} < STORE_BITS;
   assign lc_ok   = lc_ff < MAX_B;
   assign raddr_a = sys_ok ? ei_ff[AW+2:3] : '0;
   assign raddr_b = ilv_ok ? pa_ff[AW+2:3] : '0;
   assign waddr   = lc_ok ? lc_ff[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (do_load && lc_ok) begin
         store_mem[waddr] <= req_data_byte;
      end
      rd_a_ff <= store_mem[raddr_a];
      rd_b_ff <= store_mem[raddr_b];
   end

   // ---------------- emit datapath ----------------
   assign do_load = cmd.item_take && (req_opcode == tqpp_pkg::OP_LOAD) && !full_ff;
   assign do_emit = cmd.item_take && (req_opcode == tqpp_pkg::OP_EMIT) && full_ff;
   assign in_data = ei_ff < k_bits;

   // bytes land MSB first: bit b of a byte is word bit 7-b
   assign sys_bit = sys_ok ? rd_a_ff[~ei_ff[2:0]] : 1'b0;
   assign ilv_bit = ilv_ok ? rd_b_ff[~pa_ff[2:0]] : 1'b0;

   assign step1 = tqpp_pkg::rsc_step(s1_ff, sys_bit);
   assign step2 = tqpp_pkg::rsc_step(s2_ff, ilv_bit);

   assign pa_sum  = {1'b0, pam_ff} + {1'b0, pim_ff};
   assign pi_sum  = {1'b0, pim_ff} + {1'b0, dbl_ff};
   assign pa_next = (pa_sum >= {1'b0, k_bits}) ? VW'(pa_sum - {1'b0, k_bits})
                                               : pa_sum[VW-1:0];
   assign pi_next = (pi_sum >= {1'b0, k_bits}) ? VW'(pi_sum - {1'b0, k_bits})
                                               : pi_sum[VW-1:0];

   assign diff      = VW'(ei_ff - k_bits);
   assign tsel      = (diff > VW'(3)) ? 2'd3 : diff[1:0];
   assign tail_calc = {tqpp_pkg::rsc_tail(s2_ff), tqpp_pkg::rsc_tail(s1_ff)};
   assign tail_use  = (tsel == 2'd0) ? tail_calc : tail_ff;

   always_comb begin
      unique case (tsel)
         2'd0:    trip = tail_use[2:0];
         2'd1:    trip = tail_use[5:3];
         2'd2:    trip = tail_use[8:6];
         default: trip = tail_use[11:9];
      endcase
   end

   assign lc_inc = BW'(lc_ff + 1'b1);

   always_comb begin
      lc_in   = lc_ff;
      ei_in   = ei_ff;
      pa_in   = pa_ff;
      pam_in  = pam_ff;
      pi_in   = pi_ff;
      pim_in  = pim_ff;
      s1_in   = s1_ff;
      s2_in   = s2_ff;
      tail_in = tail_ff;
      full_in = full_ff;

      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_third_in  = rsp_third_ff;
      rsp_end_in    = rsp_end_ff;

      if (cmd.red_fix) begin
         pam_in = r_pa;
         pim_in = r_pi;
      end

      if (do_load) begin
         lc_in = lc_inc;
         if (lc_inc >= eff_bytes) begin
            full_in = 1'b1;
            ei_in   = '0;
            pa_in   = '0;
            pam_in  = '0;
            pi_in   = sumf_ff;
            pim_in  = sumf_ff;
            s1_in   = '0;
            s2_in   = '0;
            tail_in = '0;
         end
      end

      if (do_emit) begin
         rsp_valid_in = 1'b1;
         if (in_data) begin
            rsp_first_in  = sys_bit;
            rsp_second_in = step1[3];
            rsp_third_in  = step2[3];
            rsp_end_in    = 1'b0;
            s1_in         = step1[2:0];
            s2_in         = step2[2:0];
            pa_in         = pa_next;
            pam_in        = pa_next;
            pi_in         = pi_next;
            pim_in        = pi_next;
            ei_in         = VW'(ei_ff + 1'b1);
         end else begin
            rsp_first_in  = trip[0];
            rsp_second_in = trip[1];
            rsp_third_in  = trip[2];
            rsp_end_in    = (tsel == 2'd3);
            if (tsel == 2'd0) begin
               tail_in = tail_calc;
            end
            if (tsel == 2'd3) begin
               full_in = 1'b0;
               lc_in   = '0;
               ei_in   = '0;
            end else begin
               ei_in = VW'(ei_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff     <= tqpp_pkg::RST_BLOCK_BYTES;
         f1_ff        <= tqpp_pkg::RST_F1;
         f2_ff        <= tqpp_pkg::RST_F2;
         lc_ff        <= '0;
         ei_ff        <= '0;
         pa_ff        <= '0;
         pam_ff       <= '0;
         pi_ff        <= '0;
         pim_ff       <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         tail_ff      <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bytes_ff     <= bytes_in;
         f1_ff        <= f1_in;
         f2_ff        <= f2_in;
         lc_ff        <= lc_in;
         ei_ff        <= ei_in;
         pa_ff        <= pa_in;
         pam_ff       <= pam_in;
         pi_ff        <= pi_in;
         pim_ff       <= pim_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         tail_ff      <= tail_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sumf_ff       <= sumf_in;
      dbl_ff        <= dbl_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_third_ff  <= rsp_third_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign status.cfg_write = csr_valid;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_first_bit  = rsp_first_ff;
   assign rsp_second_bit = rsp_second_ff;
   assign rsp_third_bit  = rsp_third_ff;
   assign rsp_block_end  = rsp_end_ff;

endmodule

>>> hdl/tqpp_checker.sv
`timescale 1ns / 1ps

module tqpp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic csr_valid,
   input logic csr_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_first_bit,
   input logic rsp_second_bit,
   input logic rsp_third_bit,
   input logic rsp_block_end
);

   // a taken word is followed by a settle state with req_ready low
   a_settle_after_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req ready high right after an accepted word");

   // a register write stalls the input while coefficients are reduced
   a_stall_after_csr: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !req_ready)
      else $error("req ready high right after a register write");

   // a result only appears after an accepted word
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an accepted word");

   // a stalled result holds
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_first_bit)
         && $stable(rsp_second_bit) && $stable(rsp_third_bit)
         && $stable(rsp_block_end)))
      else $error("stalled result changed");

endmodule

bind turbo_encoder_qpp_unit tqpp_checker u_tqpp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .csr_valid      (csr_bus.valid),
   .csr_ready      (csr_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_first_bit  (rsp_bus.first_bit),
   .rsp_second_bit (rsp_bus.second_bit),
   .rsp_third_bit  (rsp_bus.third_bit),
   .rsp_block_end  (rsp_bus.block_end)
);
